// ----- rtl/core/lss_pkg.sv -----
// Shared types, constants and character-class helpers for the line substring search.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lss_pkg;

  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned PAT_REGS      = 4;
  localparam int unsigned PAT_REG_W     = 64;
  localparam int unsigned PAT_REG_CHARS = PAT_REGS * PAT_REG_W / CHAR_W;
  localparam int unsigned PLEN_W        = 6;
  localparam int unsigned FROM_W        = 12;
  localparam int unsigned MCOL_W        = 12;
  localparam int unsigned APB_DATA_W    = 64;
  localparam int unsigned APB_ADDR_W    = 6;
  localparam int unsigned REG_IDX_W     = 3;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CASE_FLIP  = 8'h20;

  // register indexes (byte address is 8 times the index)
  localparam logic [REG_IDX_W-1:0] REG_PAT_LOW     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_SECOND  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT_THIRD   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT_HIGH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAT_LENGTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MATCH_CASE  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WHOLE_WORD  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SKIP_INDENT = 3'd7;

  typedef struct packed {
    logic [PAT_REGS-1:0][PAT_REG_W-1:0] chars;
    logic [PLEN_W-1:0]                  len;
    logic                               match_case;
    logic                               whole_word;
    logic                               skip_indented;
  } cfg_t;

  typedef struct packed {
    logic hit;       // window ends with the pattern
    logic bnd_word;  // byte just before the candidate is a word byte
  } match_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_word(input logic [CHAR_W-1:0] c);
    return is_letter(c) || ((c >= "0") && (c <= "9")) || (c == "_");
  endfunction

  function automatic logic char_eq(input logic [CHAR_W-1:0] t,
                                   input logic [CHAR_W-1:0] p,
                                   input logic              exact);
    return (t == p) || (!exact && is_letter(p) && (t == (p ^ CASE_FLIP)));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/line_substring_search.sv -----
// Line substring search, top level: input register, line state, result register.
// A character transfer is captured in the input register and processed from there;
// the line result stays on the output until taken. One character per cycle is taken
// unless a line end waits on a full result slot; the window compare is combinational.
// Reset: rst_ni clears configuration, line state and both valid flags at once.
// Depends on lss_pkg, lss_cfg_regs and lss_matcher.
`default_nettype none

module line_substring_search import lss_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned LINE_MAX    = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // text stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [23:0]           s_axis_tdata,  // [7:0] text_char, [19:8] from_column
  input  wire logic                  s_axis_tlast,  // end_of_line
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [15:0]           m_axis_tdata,  // [11:0] match_column
  output logic                       m_axis_tuser,  // found
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned CW   = $clog2(LINE_MAX);
  localparam int unsigned CMPW = (CW + 1 > PLEN_W) ? CW + 1 : PLEN_W;
  localparam int unsigned SW   = (CW > FROM_W) ? CW : FROM_W;
  localparam logic [CW-1:0] COL_LAST = CW'(LINE_MAX - 1);

  cfg_t   cfg;
  match_t mt;

  // input register
  logic              in_valid_q;
  logic [CHAR_W-1:0] in_char_q;
  logic              in_eol_q;
  logic [FROM_W-1:0] in_from_q;

  // line state
  logic          line_found_q, line_found_d;
  logic [CW-1:0] found_start_q, found_start_d;
  logic          pending_q, pending_d;
  logic [CW-1:0] pending_start_q, pending_start_d;
  logic          ignored_q, ignored_d;
  logic [CW-1:0] col_q, col_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  logic [MCOL_W-1:0] out_col_q, out_col_d;

  logic            adv;
  logic            in_take;
  logic [CMPW-1:0] col_p1;
  logic [CMPW-1:0] len_c;
  logic [CMPW-1:0] start_c;
  logic [CW-1:0]   start;
  logic            qualifies;
  logic            lf1;
  logic [CW-1:0]   fs1;
  logic            ign1;
  logic            fnd;

  lss_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lss_matcher #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_match (
    .clk_i   (clk_i),
    .shift_i (adv),
    .char_i  (in_char_q),
    .cfg_i   (cfg),
    .match_o (mt)
  );

  // a line end may only advance when the result slot is free or draining
  assign adv           = in_valid_q && (!in_eol_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = 16'(out_col_q);

  assign col_p1  = CMPW'(col_q) + CMPW'(1);
  assign len_c   = CMPW'(cfg.len);
  assign start_c = col_p1 - len_c;
  assign start   = start_c[CW-1:0];
  assign qualifies = mt.hit && (col_p1 >= len_c) && (SW'(start) >= SW'(in_from_q));

  always_comb begin
    line_found_d    = line_found_q;
    found_start_d   = found_start_q;
    pending_d       = pending_q;
    pending_start_d = pending_start_q;
    ignored_d       = ignored_q;
    col_d           = col_q;
    out_valid_d     = out_valid_q && !m_axis_tready;
    out_found_d     = out_found_q;
    out_col_d       = out_col_q;
    lf1  = line_found_q;
    fs1  = found_start_q;
    ign1 = ignored_q;
    fnd  = 1'b0;

    if (adv) begin
      ign1 = ignored_q || ((col_q == '0) && cfg.skip_indented && (in_char_q == CHAR_SPACE));

      // a waiting whole-word candidate succeeds on a following non-word byte
      if (pending_q && !is_word(in_char_q) && !line_found_q) begin
        lf1 = 1'b1;
        fs1 = pending_start_q;
      end
      pending_d       = 1'b0;
      pending_start_d = pending_start_q;
      line_found_d    = lf1;
      found_start_d   = fs1;

      if (qualifies) begin
        if (!cfg.whole_word) begin
          if (!lf1) begin
            line_found_d  = 1'b1;
            found_start_d = start;
          end
        end else if ((start == '0) || !mt.bnd_word) begin
          if (in_eol_q) begin
            if (!lf1) begin
              line_found_d  = 1'b1;
              found_start_d = start;
            end
          end else if (!lf1) begin
            pending_d       = 1'b1;
            pending_start_d = start;
          end
        end
      end

      ignored_d = ign1;
      col_d     = (col_q < COL_LAST) ? col_q + CW'(1) : col_q;

      if (in_eol_q) begin
        fnd         = line_found_d && !ign1;
        out_valid_d = 1'b1;
        out_found_d = fnd;
        out_col_d   = fnd ? MCOL_W'(SW'(found_start_d)) : '0;
        // clear the line state for the next line
        line_found_d    = 1'b0;
        found_start_d   = '0;
        pending_d       = 1'b0;
        pending_start_d = '0;
        ignored_d       = 1'b0;
        col_d           = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      line_found_q    <= 1'b0;
      found_start_q   <= '0;
      pending_q       <= 1'b0;
      pending_start_q <= '0;
      ignored_q       <= 1'b0;
      col_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      in_valid_q      <= in_take || (in_valid_q && !adv);
      line_found_q    <= line_found_d;
      found_start_q   <= found_start_d;
      pending_q       <= pending_d;
      pending_start_q <= pending_start_d;
      ignored_q       <= ignored_d;
      col_q           <= col_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata[CHAR_W-1:0];
      in_eol_q  <= s_axis_tlast;
      in_from_q <= s_axis_tdata[CHAR_W +: FROM_W];
    end
    out_found_q <= out_found_d;
    out_col_q   <= out_col_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/lss_cfg_regs.sv -----
// APB-style register file holding the pattern and the search options.
// Depends on lss_pkg for the register map and the configuration struct.
`default_nettype none

module lss_cfg_regs import lss_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t                 cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[APB_ADDR_W-1 -: REG_IDX_W];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PAT_LOW:     cfg_d.chars[0]      = pwdata;
        REG_PAT_SECOND:  cfg_d.chars[1]      = pwdata;
        REG_PAT_THIRD:   cfg_d.chars[2]      = pwdata;
        REG_PAT_HIGH:    cfg_d.chars[3]      = pwdata;
        REG_PAT_LENGTH:  cfg_d.len           = pwdata[PLEN_W-1:0];
        REG_MATCH_CASE:  cfg_d.match_case    = pwdata[0];
        REG_WHOLE_WORD:  cfg_d.whole_word    = pwdata[0];
        REG_SKIP_INDENT: cfg_d.skip_indented = pwdata[0];
        default:         cfg_d               = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAT_LOW:     prdata = cfg_q.chars[0];
      REG_PAT_SECOND:  prdata = cfg_q.chars[1];
      REG_PAT_THIRD:   prdata = cfg_q.chars[2];
      REG_PAT_HIGH:    prdata = cfg_q.chars[3];
      REG_PAT_LENGTH:  prdata = APB_DATA_W'(cfg_q.len);
      REG_MATCH_CASE:  prdata = APB_DATA_W'(cfg_q.match_case);
      REG_WHOLE_WORD:  prdata = APB_DATA_W'(cfg_q.whole_word);
      REG_SKIP_INDENT: prdata = APB_DATA_W'(cfg_q.skip_indented);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lss_matcher.sv -----
// Character window and parallel pattern compare for every pattern length.
// Depends on lss_pkg for cfg_t, match_t and the character helpers.
`default_nettype none

module lss_matcher import lss_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  wire logic              clk_i,
  input  wire logic              shift_i,
  input  wire logic [CHAR_W-1:0] char_i,
  input  wire cfg_t              cfg_i,
  output match_t                 match_o
);

  localparam int unsigned LCMP_W = 7;

  logic [CHAR_W-1:0]      win_q [PATTERN_MAX];
  logic [CHAR_W-1:0]      win_d [PATTERN_MAX];
  logic [CHAR_W-1:0]      cur   [PATTERN_MAX];
  logic [CHAR_W-1:0]      pat   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eqm   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hit_len;
  logic [CHAR_W-1:0]      bnd_char;
  logic [PAT_REGS*PAT_REG_W-1:0] pat_flat;

  assign pat_flat = cfg_i.chars;

  // window as it stands once the incoming byte is in: cur[0] is newest
  assign cur[0] = char_i;
  for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_cur
    assign cur[k] = win_q[k-1];
  end

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
    if (j < PAT_REG_CHARS) begin : g_reg
      assign pat[j] = pat_flat[CHAR_W*j +: CHAR_W];
    end else begin : g_zero
      assign pat[j] = '0;
    end
  end

  // pattern char j lines up with window byte l-1-j for a length-l pattern
  for (genvar l = 1; l <= PATTERN_MAX; l++) begin : g_len
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_chr
      if (j < l) begin : g_cmp
        assign eqm[l-1][j] = char_eq(cur[l-1-j], pat[j], cfg_i.match_case);
      end else begin : g_pad
        assign eqm[l-1][j] = 1'b1;
      end
    end
    assign hit_len[l-1] = &eqm[l-1];
  end

  always_comb begin
    match_o  = '0;
    bnd_char = '0;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      if (LCMP_W'(cfg_i.len) == LCMP_W'(l)) begin
        match_o.hit = hit_len[l-1];
        bnd_char    = win_q[l-1];
      end
    end
    match_o.bnd_word = is_word(bnd_char);
  end

  always_comb begin
    win_d = win_q;
    if (shift_i) begin
      win_d[0] = char_i;
      for (int k = 1; k < PATTERN_MAX; k++) begin
        win_d[k] = win_q[k-1];
      end
    end
  end

  // window bytes of an earlier line are never looked at, so no clear is needed
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for line_substring_search: streams text lines, checks each
// end-of-line result against an in-bench model of the window search or a typed value.
// Depends on lss_pkg and the line_substring_search RTL.
`timescale 1ns / 1ps

module tb;
  import lss_pkg::*;

  localparam int unsigned LINE_LIMIT     = 4096;
  localparam int unsigned WINDOW_DEPTH   = PAT_REG_CHARS + 1;
  localparam int unsigned RANDOM_ITEMS   = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned SHOW_LIMIT     = 10;

  typedef struct packed {
    logic              found;
    logic [MCOL_W-1:0] col;
  } line_result_t;

  typedef struct packed {
    logic                  is_write;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [PAT_REG_W-1:0]  wdata;
    logic [CHAR_W-1:0]     ch;
    logic                  eol;
    logic [FROM_W-1:0]     from_col;
    logic                  typed;
    logic                  t_found;
    logic [MCOL_W-1:0]     t_col;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;   // [7:0] text_char, [19:8] from_column
  logic                  s_axis_tlast;   // end_of_line
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [15:0]           m_axis_tdata;   // [11:0] match_column
  logic                  m_axis_tuser;   // found
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // shadow configuration
  logic [PAT_REGS-1:0][PAT_REG_W-1:0] pat_regs;
  logic [PLEN_W-1:0]                  pat_len;
  logic                               exact_case;
  logic                               word_mode;
  logic                               skip_mode;

  // shadow line state
  logic [CHAR_W-1:0] win [WINDOW_DEPTH];
  int unsigned       line_col;
  bit                line_hit;
  int unsigned       hit_start;
  bit                cand_open;
  int unsigned       cand_start;
  bit                line_skipped;

  line_result_t line_results_q [$];
  stim_row_t    directed_q [$];
  int unsigned  fail_count;
  int unsigned  stall_cycles;
  bit           src_steady;
  bit           sink_steady;

  line_substring_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit letter_byte(input logic [CHAR_W-1:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit word_byte(input logic [CHAR_W-1:0] c);
    return letter_byte(c) || (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic bit chars_match(input logic [CHAR_W-1:0] t, input logic [CHAR_W-1:0] p);
    if (t == p) return 1'b1;
    return !exact_case && letter_byte(p) && t == (p ^ CASE_FLIP);
  endfunction

  function automatic logic [CHAR_W-1:0] pat_char(input int unsigned j);
    if (j >= PAT_REG_CHARS) return '0;
    return pat_regs[j / 8][(j % 8) * 8 +: 8];
  endfunction

  function automatic void clear_line_state();
    for (int i = 0; i < WINDOW_DEPTH; i++) win[i] = '0;
    line_col     = 0;
    line_hit     = 0;
    hit_start    = 0;
    cand_open    = 0;
    cand_start   = 0;
    line_skipped = 0;
  endfunction

  function automatic void note_match(input int unsigned start);
    if (!line_hit) begin
      line_hit  = 1;
      hit_start = start;
    end
  endfunction

  // Advance the search by one character; a result comes out only at end of line.
  function automatic void search_step(input logic [CHAR_W-1:0] x, input logic eol,
                                      input logic [FROM_W-1:0] from_col,
                                      output bit has_res, output line_result_t res);
    int unsigned col;
    int unsigned len;
    int unsigned start;
    bit          hit;
    col     = line_col;
    len     = pat_len;
    has_res = 0;
    res     = '0;
    if (col == 0 && skip_mode && x == CHAR_SPACE) line_skipped = 1;
    if (cand_open) begin
      if (!word_byte(x)) note_match(cand_start);
      cand_open = 0;
    end
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = x;
    if (len >= 1 && len <= PAT_REG_CHARS && col + 1 >= len) begin
      hit = 1;
      for (int j = 0; j < len; j++) hit &= chars_match(win[len - 1 - j], pat_char(j));
      if (hit) begin
        start = col + 1 - len;
        if (start >= from_col) begin
          if (!word_mode) begin
            note_match(start);
          end else if (start == 0 || !word_byte(win[len])) begin
            // hold the candidate until the next byte shows whether the word ends
            if (eol) begin
              note_match(start);
            end else if (!line_hit) begin
              cand_open  = 1;
              cand_start = start;
            end
          end
        end
      end
    end
    if (line_col < LINE_LIMIT - 1) line_col++;
    if (eol) begin
      has_res   = 1;
      res.found = line_hit && !line_skipped;
      res.col   = res.found ? hit_start[MCOL_W-1:0] : '0;
      clear_line_state();
    end
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 11))
      0: return "a";
      1: return "A";
      2: return "b";
      3: return "B";
      4: return "_";
      5: return "1";
      6: return CHAR_SPACE;
      7: return ".";
      8: return "-";
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void row_write(input logic [REG_IDX_W-1:0] idx,
                                    input logic [PAT_REG_W-1:0] val);
    stim_row_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.wdata    = val;
    directed_q.push_back(r);
  endfunction

  function automatic void row_char(input logic [CHAR_W-1:0] ch);
    stim_row_t r;
    r    = '0;
    r.ch = ch;
    directed_q.push_back(r);
  endfunction

  function automatic void row_eol(input logic [CHAR_W-1:0] ch, input logic [FROM_W-1:0] from_col,
                                  input logic typed, input logic t_found,
                                  input logic [MCOL_W-1:0] t_col);
    stim_row_t r;
    r          = '0;
    r.ch       = ch;
    r.eol      = 1'b1;
    r.from_col = from_col;
    r.typed    = typed;
    r.t_found  = t_found;
    r.t_col    = t_col;
    directed_q.push_back(r);
  endfunction

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_PAT_LOW:     pat_regs[0] = val;
      REG_PAT_SECOND:  pat_regs[1] = val;
      REG_PAT_THIRD:   pat_regs[2] = val;
      REG_PAT_HIGH:    pat_regs[3] = val;
      REG_PAT_LENGTH:  pat_len     = val[PLEN_W-1:0];
      REG_MATCH_CASE:  exact_case  = val[0];
      REG_WHOLE_WORD:  word_mode   = val[0];
      REG_SKIP_INDENT: skip_mode   = val[0];
      default: ;
    endcase
  endtask

  // Drop valid and hold off until every pending line result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] x, input logic eol,
                           input logic [FROM_W-1:0] from_col, input logic typed,
                           input logic t_found, input logic [MCOL_W-1:0] t_col);
    int unsigned  gap;
    bit           has_res;
    line_result_t res;
    gap = src_steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {4'b0000, from_col, x};
    s_axis_tlast  <= eol;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    search_step(x, eol, from_col, has_res, res);
    if (has_res) begin
      if (typed) begin
        res.found = t_found;
        res.col   = t_col;
      end
      line_results_q.push_back(res);
    end
  endtask

  task automatic random_setup();
    int unsigned len;
    logic [PAT_REG_W-1:0] word;
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = PAT_REG_CHARS;
      2: len = $urandom_range(PAT_REG_CHARS + 1, 63);
      3: len = 1;
      default: len = $urandom_range(2, 6);
    endcase
    for (int r = 0; r < PAT_REGS; r++) begin
      if ($urandom_range(0, 5) == 0) begin
        word = {$urandom, $urandom};
      end else begin
        for (int k = 0; k < 8; k++) word[k*8 +: 8] = pick_char();
      end
      apb_write(REG_IDX_W'(r), word);
    end
    apb_write(REG_PAT_LENGTH, APB_DATA_W'(len));
    apb_write(REG_MATCH_CASE, APB_DATA_W'($urandom_range(0, 1)));
    apb_write(REG_WHOLE_WORD, APB_DATA_W'($urandom_range(0, 1)));
    apb_write(REG_SKIP_INDENT, APB_DATA_W'($urandom_range(0, 1)));
  endtask

  task automatic random_line(output int unsigned sent);
    logic [CHAR_W-1:0] line_q [$];
    logic [CHAR_W-1:0] c;
    logic [FROM_W-1:0] from_col;
    int unsigned       len;
    int unsigned       line_len;
    int unsigned       pos;
    len      = pat_len;
    line_len = $urandom_range(1, ((len >= 1 && len <= PAT_REG_CHARS) ? len : 4) + 10);
    for (int i = 0; i < line_len; i++) line_q.push_back(pick_char());
    if ($urandom_range(0, 5) == 0) line_q[0] = CHAR_SPACE;
    // plant copies of the pattern, letters in either case
    if (len >= 1 && len <= PAT_REG_CHARS && line_len >= len) begin
      repeat ($urandom_range(0, 2)) begin
        pos = $urandom_range(0, line_len - len);
        for (int j = 0; j < len; j++) begin
          c = pat_char(j);
          if (letter_byte(c) && $urandom_range(0, 2) == 0) c = c ^ CASE_FLIP;
          line_q[pos + j] = c;
        end
      end
    end
    case ($urandom_range(0, 5))
      0, 1, 2: from_col = '0;
      3:       from_col = FROM_W'($urandom_range(0, line_len));
      4:       from_col = '1;
      default: from_col = FROM_W'($urandom_range(0, 4095));
    endcase
    for (int i = 0; i < line_len; i++)
      send_char(line_q[i], i == line_len - 1, from_col, 1'b0, 1'b0, '0);
    sent = line_len;
  endtask

  // result side: random stalls, compare each transfer with the oldest expectation
  initial begin
    int unsigned  gap;
    line_result_t want;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = sink_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (line_results_q.size() == 0) begin
        if (fail_count < SHOW_LIMIT)
          $display("%0t: unexpected result found=%0b column=%0d", $realtime, m_axis_tuser,
                   m_axis_tdata[MCOL_W-1:0]);
        fail_count++;
      end else begin
        want = line_results_q.pop_front();
        if (m_axis_tuser !== want.found || m_axis_tdata[MCOL_W-1:0] !== want.col) begin
          if (fail_count < SHOW_LIMIT)
            $display("%0t: mismatch expected found=%0b column=%0d, got found=%0b column=%0d",
                     $realtime, want.found, want.col, m_axis_tuser, m_axis_tdata[MCOL_W-1:0]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned rand_items;
    int unsigned sent;
    stim_row_t   row;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    fail_count  = 0;
    src_steady  = 0;
    sink_steady = 0;
    pat_regs    = '0;
    pat_len     = '0;
    exact_case  = 0;
    word_mode   = 0;
    skip_mode   = 0;
    clear_line_state();

    // empty pattern straight after reset
    row_eol("a", 12'd0, 1'b1, 1'b0, 12'd0);
    row_write(REG_PAT_LOW, 64'h6261);
    row_write(REG_PAT_LENGTH, 64'd2);
    row_char("x");
    row_char("A");
    row_eol("B", 12'd0, 1'b1, 1'b1, 12'd1);
    row_char("a");
    row_eol("b", 12'd4095, 1'b1, 1'b0, 12'd0);
    row_write(REG_MATCH_CASE, 64'd1);
    row_char("A");
    row_char("b");
    row_char(" ");
    row_char("a");
    row_eol("b", 12'd0, 1'b0, 1'b0, 12'd0);
    // whole word: line edge closes the candidate, a trailing word byte kills it
    row_write(REG_MATCH_CASE, 64'd0);
    row_write(REG_WHOLE_WORD, 64'd1);
    row_char("a");
    row_eol("b", 12'd0, 1'b1, 1'b1, 12'd0);
    row_char(" ");
    row_char("a");
    row_char("b");
    row_eol("_", 12'd0, 1'b1, 1'b0, 12'd0);
    row_write(REG_SKIP_INDENT, 64'd1);
    row_char(" ");
    row_char("a");
    row_eol("b", 12'd0, 1'b1, 1'b0, 12'd0);
    // pattern longer than the window never matches
    row_write(REG_PAT_LENGTH, 64'd33);
    row_write(REG_SKIP_INDENT, 64'd0);
    row_write(REG_WHOLE_WORD, 64'd0);
    row_char("a");
    row_eol("b", 12'd0, 1'b1, 1'b0, 12'd0);
    // zero and all-ones bytes are plain characters
    row_write(REG_PAT_LOW, 64'hFF00);
    row_write(REG_PAT_LENGTH, 64'd2);
    row_char(8'h00);
    row_eol(8'hFF, 12'd0, 1'b1, 1'b1, 12'd0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) begin
      row = directed_q[i];
      if (row.is_write) begin
        drain_results();
        apb_write(row.reg_idx, row.wdata);
      end else begin
        send_char(row.ch, row.eol, row.from_col, row.typed, row.t_found, row.t_col);
      end
    end

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      drain_results();
      random_setup();
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 12)) begin
        random_line(sent);
        rand_items += sent;
      end
    end

    // one line past the column limit, pattern only at its very end
    drain_results();
    apb_write(REG_PAT_LOW, 64'h7A7978);
    apb_write(REG_PAT_LENGTH, 64'd3);
    apb_write(REG_MATCH_CASE, 64'd0);
    apb_write(REG_WHOLE_WORD, 64'd0);
    apb_write(REG_SKIP_INDENT, 64'd0);
    for (int i = 0; i < LINE_LIMIT + 4; i++) begin
      if (i >= LINE_LIMIT + 1)
        send_char(pat_char(i - LINE_LIMIT - 1), i == LINE_LIMIT + 3, 12'd0, 1'b0, 1'b0, '0);
      else
        send_char(".", 1'b0, 12'd0, 1'b0, 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    fail_count += line_results_q.size();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
